/* design/pfc_pkg.sv */
// Shared types, format codes and pack/unpack functions of the pixel format converter.
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

    localparam int FMT_W  = 3;
    localparam int CH_W   = 8;
    localparam int PIX_W  = 32;
    localparam int SUM_W  = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic [FMT_W-1:0] FMT_RGBA8   = 3'd0;
    localparam logic [FMT_W-1:0] FMT_RGBA4   = 3'd1;
    localparam logic [FMT_W-1:0] FMT_RGB5_A1 = 3'd2;
    localparam logic [FMT_W-1:0] FMT_RGB8    = 3'd3;
    localparam logic [FMT_W-1:0] FMT_RGB565  = 3'd4;
    localparam logic [FMT_W-1:0] FMT_LA8     = 3'd5;
    localparam logic [FMT_W-1:0] FMT_L8      = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_FORMAT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_FORMAT = 1'd1;

    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // floor(n / 3) == (n * 683) >> 11 for every n up to 765
    localparam logic [SUM_W:0] DIV3_RECIP = 11'd683;
    localparam int DIV3_SHIFT = 11;

    typedef struct packed {
        logic [CH_W-1:0] a;
        logic [CH_W-1:0] b;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] r;
    } chan_t;

    // The unused code seven behaves as L8.
    function automatic logic [FMT_W-1:0] fmt_clamp(input logic [FMT_W-1:0] code);
        return (code > FMT_L8) ? FMT_L8 : code;
    endfunction

    function automatic logic fmt_is_luma(input logic [FMT_W-1:0] code);
        logic [FMT_W-1:0] c;
        c = fmt_clamp(code);
        return (c == FMT_LA8) || (c == FMT_L8);
    endfunction

    // Widen every channel to 8 bits; fill missing ones.
    function automatic chan_t unpack_pixel(input logic [FMT_W-1:0] code,
                                           input logic [PIX_W-1:0] p);
        chan_t ch;
        ch = '0;
        unique case (fmt_clamp(code))
            FMT_RGBA8:
            begin
                ch.r = p[7:0];
                ch.g = p[15:8];
                ch.b = p[23:16];
                ch.a = p[31:24];
            end
            FMT_RGBA4:
            begin
                ch.r = {p[3:0], 4'b0};
                ch.g = {p[7:4], 4'b0};
                ch.b = {p[11:8], 4'b0};
                ch.a = {p[15:12], 4'b0};
            end
            FMT_RGB5_A1:
            begin
                ch.r = {p[4:0], 3'b0};
                ch.g = {p[9:5], 3'b0};
                ch.b = {p[14:10], 3'b0};
                ch.a = {p[15], 7'b0};
            end
            FMT_RGB8:
            begin
                ch.r = p[7:0];
                ch.g = p[15:8];
                ch.b = p[23:16];
                ch.a = ALPHA_OPAQUE;
            end
            FMT_RGB565:
            begin
                ch.r = {p[4:0], 3'b0};
                ch.g = {p[10:5], 2'b0};
                ch.b = {p[15:11], 3'b0};
                ch.a = ALPHA_OPAQUE;
            end
            FMT_LA8:
            begin
                ch.r = p[7:0];
                ch.g = p[7:0];
                ch.b = p[7:0];
                ch.a = p[15:8];
            end
            default:
            begin
                ch.r = p[7:0];
                ch.g = p[7:0];
                ch.b = p[7:0];
                ch.a = ALPHA_OPAQUE;
            end
        endcase
        return ch;
    endfunction

    // Keep the top bits of every channel; zero the unused upper bits.
    function automatic logic [PIX_W-1:0] pack_pixel(input logic [FMT_W-1:0] code,
                                                    input chan_t ch);
        logic [PIX_W-1:0] p;
        p = '0;
        unique case (fmt_clamp(code))
            FMT_RGBA8:   p = {ch.a, ch.b, ch.g, ch.r};
            FMT_RGBA4:   p = {16'b0, ch.a[7:4], ch.b[7:4], ch.g[7:4], ch.r[7:4]};
            FMT_RGB5_A1: p = {16'b0, ch.a[7], ch.b[7:3], ch.g[7:3], ch.r[7:3]};
            FMT_RGB8:    p = {8'b0, ch.b, ch.g, ch.r};
            FMT_RGB565:  p = {16'b0, ch.b[7:3], ch.g[7:2], ch.r[7:3]};
            FMT_LA8:     p = {16'b0, ch.a, ch.r};
            default:     p = {24'b0, ch.r};
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

/* design/pfc_div3.sv */
// Divide-by-three of the luminance sum by a reciprocal multiply.
`timescale 1ns / 1ps
`default_nettype none

module pfc_div3
    import pfc_pkg::*;
(
    input  wire logic [SUM_W-1:0] sum,
    output logic      [CH_W-1:0]  quot
);

    logic [2*SUM_W:0] prod;

    assign prod = {{(SUM_W+1){1'b0}}, sum} * {{SUM_W{1'b0}}, DIV3_RECIP};
    assign quot = prod[DIV3_SHIFT +: CH_W];

endmodule

`default_nettype wire

/* design/pixel_format_converter.sv */
// Top level of the pixel format converter: config registers and the four-stage pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Converts one packed pixel per item between RGBA8, RGBA4, RGB5_A1, RGB8, RGB565,
// LA8 and L8, chosen by source_format and target_format (write these only while no
// item is in flight). The pipeline has four register stages: unpack, channel sum,
// luminance divide-by-three, pack into the output register. An accepted item passes
// through the unpack, sum and divide registers before out_valid rises; one item is
// taken every cycle when out_ready stays high, and each stage keeps taking items
// while it or any later stage has a free slot.

module pixel_format_converter
    import pfc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [FMT_W-1:0]     cfg_data,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [PIX_W-1:0]     in_pixel,
    input  wire logic                 in_last,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [PIX_W-1:0]     out_pixel,
    output logic                      out_last
);

    logic [FMT_W-1:0] src_fmt_reg;
    logic [FMT_W-1:0] dst_fmt_reg;

    logic             s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic             s1_ready, s2_ready, s3_ready, s4_ready;
    chan_t            s1_ch_reg, s2_ch_reg, s3_ch_reg;
    chan_t            s1_ch_next, s3_ch_next;
    logic             s1_last_reg, s2_last_reg, s3_last_reg, out_last_reg;
    logic [SUM_W-1:0] s2_sum_reg, s2_sum_next;
    logic [CH_W-1:0]  luma;
    logic [PIX_W-1:0] out_pixel_reg, out_pixel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_fmt_reg <= FMT_RGBA8;
            dst_fmt_reg <= FMT_RGBA8;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SOURCE_FORMAT: src_fmt_reg <= cfg_data;
                REG_TARGET_FORMAT: dst_fmt_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // A stage takes a new item when it is empty or its item moves on.
    assign s4_ready = !out_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign s1_ch_next  = unpack_pixel(src_fmt_reg, in_pixel);
    assign s2_sum_next = {2'b0, s1_ch_reg.r} + {2'b0, s1_ch_reg.g} + {2'b0, s1_ch_reg.b};

    pfc_div3 u_div3
    (
        .sum  (s2_sum_reg),
        .quot (luma)
    );

    always_comb
    begin
        s3_ch_next = s2_ch_reg;
        if (fmt_is_luma(dst_fmt_reg))
        begin
            s3_ch_next.r = luma;
        end
    end

    assign out_pixel_next = pack_pixel(dst_fmt_reg, s3_ch_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_ch_reg   <= s1_ch_next;
            s1_last_reg <= in_last;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_ch_reg   <= s1_ch_reg;
            s2_sum_reg  <= s2_sum_next;
            s2_last_reg <= s1_last_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_ch_reg   <= s3_ch_next;
            s3_last_reg <= s2_last_reg;
        end
        if (s4_ready && s3_valid_reg)
        begin
            out_pixel_reg <= out_pixel_next;
            out_last_reg  <= s3_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_last  = out_last_reg;

    // Accepted item lands in the unpack stage.
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("accepted item missing from unpack stage");

    // A stalled sum stage holds its item.
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s3_ready |=> s2_valid_reg && $stable(s2_sum_reg)
                                      && $stable(s2_last_reg))
        else $error("sum stage dropped a stalled item");

    // Quotient is the exact floor of sum / 3.
    a_div3_exact: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> ({2'b0, luma} * 10'd3 <= s2_sum_reg)
                         && (s2_sum_reg - {2'b0, luma} * 10'd3 < 10'd3))
        else $error("luminance divide out of range");

    // A held result stays valid until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_pixel_reg))
        else $error("output item lost while stalled");

endmodule

`default_nettype wire

/* tb/sv/pixel_format_converter_tb.sv */
// Self-checking testbench of the pixel format converter: formats, random pixels, stalls.
`timescale 1ns / 1ps

module pixel_format_converter_tb;
    import pfc_pkg::*;

    localparam int LATENCY     = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 1700;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } pixel_item_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_SOURCE_FORMAT;
    logic [FMT_W-1:0]     cfg_data = FMT_RGBA8;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [PIX_W-1:0]     in_pixel = '0;
    logic                 in_last = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [PIX_W-1:0]     out_pixel;
    logic                 out_last;

    pixel_item_t pixel_queue[$];
    pixel_item_t expected_pixels[$];
    pixel_item_t next_item;
    pixel_item_t predicted;
    pixel_item_t want;
    logic [FMT_W-1:0] src_fmt = FMT_RGBA8;
    logic [FMT_W-1:0] dst_fmt = FMT_RGBA8;
    int  send_wait = 0;
    int  recv_wait = 0;
    int  recv_gap;
    bit  send_steady = 1'b0;
    bit  recv_steady = 1'b0;
    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  queued_total = 0;

    pixel_format_converter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_pixel  (in_pixel),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_pixel (out_pixel),
        .out_last  (out_last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // {bytes, R, G, B, A widths}, one nibble each
    function automatic logic [19:0] format_layout(input logic [FMT_W-1:0] code);
        case (code)
            FMT_RGBA8:   return {4'd4, 4'd8, 4'd8, 4'd8, 4'd8};
            FMT_RGBA4:   return {4'd2, 4'd4, 4'd4, 4'd4, 4'd4};
            FMT_RGB5_A1: return {4'd2, 4'd5, 4'd5, 4'd5, 4'd1};
            FMT_RGB8:    return {4'd3, 4'd8, 4'd8, 4'd8, 4'd0};
            FMT_RGB565:  return {4'd2, 4'd5, 4'd6, 4'd5, 4'd0};
            FMT_LA8:     return {4'd2, 4'd8, 4'd0, 4'd0, 4'd8};
            default:     return {4'd1, 4'd8, 4'd0, 4'd0, 4'd0};   // L8 and code seven
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] convert_pixel(input logic [FMT_W-1:0] src,
                                                       input logic [FMT_W-1:0] dst,
                                                       input logic [PIX_W-1:0] raw);
        logic [19:0]      src_lay;
        logic [19:0]      dst_lay;
        logic [63:0]      pix;
        logic [PIX_W-1:0] result;
        int unsigned      chan [4];
        int unsigned      width;
        int unsigned      pos;
        src_lay = format_layout(src);
        dst_lay = format_layout(dst);
        pix = {32'b0, raw} & ((64'd1 << (8 * src_lay[19:16])) - 64'd1);
        pos = 0;
        for (int i = 0; i < 4; i++)
        begin
            width = src_lay[15 - 4 * i -: 4];
            if (width != 0)
            begin
                chan[i] = 32'(((pix >> pos) & ((64'd1 << width) - 64'd1)) << (8 - width));
                pos += width;
            end
            else if (i == 3)
                chan[i] = ALPHA_OPAQUE;
            else if (i > 0)
                chan[i] = chan[i - 1];
            else
                chan[i] = 0;
        end
        if (dst == FMT_LA8 || dst >= FMT_L8)
            chan[0] = (chan[0] + chan[1] + chan[2]) / 3;
        result = '0;
        pos = 0;
        for (int i = 0; i < 4; i++)
        begin
            width = dst_lay[15 - 4 * i -: 4];
            if (width != 0)
            begin
                result |= (chan[i] >> (8 - width)) << pos;
                pos += width;
            end
        end
        return result;
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        logic [7:0] b;
        b = 8'($urandom);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return {4{b}};
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_pixel(input logic [PIX_W-1:0] pixel, input logic last);
        pixel_item_t item;
        item.pixel = pixel;
        item.last  = last;
        pixel_queue.push_back(item);
        queued_total++;
    endtask

    task automatic set_formats(input logic [FMT_W-1:0] src, input logic [FMT_W-1:0] dst);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_SOURCE_FORMAT;
        cfg_data  <= src;
        @(posedge clk);
        cfg_index <= REG_TARGET_FORMAT;
        cfg_data  <= dst;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Hold until every item has left the block, then let the pipeline settle.
    task automatic wait_drained();
        @(negedge clk);
        while (pixel_queue.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic run_random(input logic [FMT_W-1:0] src, input logic [FMT_W-1:0] dst);
        int count;
        count = $urandom_range(15, 35);
        set_formats(src, dst);
        repeat (count) queue_pixel(random_pixel(), $urandom_range(0, 15) == 0);
        wait_drained();
    endtask

    // Shadow of the format registers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_fmt <= FMT_RGBA8;
            dst_fmt <= FMT_RGBA8;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SOURCE_FORMAT: src_fmt <= cfg_data;
                REG_TARGET_FORMAT: dst_fmt <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_pixel  <= '0;
            in_last   <= 1'b0;
            send_wait <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predicted.pixel = convert_pixel(src_fmt, dst_fmt, in_pixel);
                predicted.last  = in_last;
                expected_pixels.push_back(predicted);
            end
            if (!in_valid || in_ready)
            begin
                if (send_wait != 0)
                begin
                    in_valid  <= 1'b0;
                    send_wait <= send_wait - 1;
                end
                else if (pixel_queue.size() != 0)
                begin
                    next_item = pixel_queue.pop_front();
                    in_valid <= 1'b1;
                    in_pixel <= next_item.pixel;
                    in_last  <= next_item.last;
                    if ($urandom_range(0, 39) == 0)
                        send_steady = !send_steady;
                    send_wait <= send_steady ? 0 : $urandom_range(0, 9);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual pixel %h last %b",
                         $time, out_pixel, out_last);
                mismatch_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (out_pixel !== want.pixel)
                begin
                    $display("%0t: out_pixel expected %h actual %h", $time, want.pixel,
                             out_pixel);
                    mismatch_count++;
                end
                if (out_last !== want.last)
                begin
                    $display("%0t: out_last expected %b actual %b", $time, want.last,
                             out_last);
                    mismatch_count++;
                end
            end
            if ($urandom_range(0, 39) == 0)
                recv_steady = !recv_steady;
            recv_gap = recv_steady ? 0 : $urandom_range(0, 9);
            out_ready <= (recv_gap == 0);
            recv_wait <= (recv_gap == 0) ? 0 : recv_gap - 1;
        end
        else if (recv_wait != 0)
        begin
            out_ready <= 1'b0;
            recv_wait <= recv_wait - 1;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Formats from reset: same source and target
        queue_pixel(32'h0000_0000, 1'b0);
        queue_pixel(32'hFFFF_FFFF, 1'b1);
        queue_pixel(32'h8040_20C1, 1'b0);
        wait_drained();

        // Same format, ignored top byte must be cleared
        set_formats(FMT_RGB8, FMT_RGB8);
        queue_pixel(32'hFF12_3456, 1'b1);
        wait_drained();

        set_formats(FMT_RGBA4, FMT_LA8);
        queue_pixel(32'hFFFF_FFFF, 1'b0);
        queue_pixel(32'h1234_5678, 1'b0);
        queue_pixel(32'h0000_0000, 1'b1);
        wait_drained();

        set_formats(FMT_RGB5_A1, FMT_RGB565);
        queue_pixel(32'hFFFF_FFFF, 1'b0);
        queue_pixel(32'h0000_8000, 1'b0);
        queue_pixel(32'h0000_7FFF, 1'b1);
        wait_drained();

        set_formats(FMT_RGB565, FMT_RGBA8);
        queue_pixel(32'hFFFF_FFFF, 1'b0);
        queue_pixel(32'h0000_F800, 1'b0);
        queue_pixel(32'h0000_07E0, 1'b1);
        wait_drained();

        // Luminance to luminance keeps the value
        set_formats(FMT_LA8, FMT_L8);
        queue_pixel(32'h0000_37C8, 1'b0);
        queue_pixel(32'hFFFF_FFFF, 1'b1);
        wait_drained();

        set_formats(FMT_L8, FMT_RGB5_A1);
        queue_pixel(32'hFFFF_FF80, 1'b0);
        queue_pixel(32'h0000_0001, 1'b1);
        wait_drained();

        // Code seven acts as L8 on either side
        set_formats(3'd7, 3'd7);
        queue_pixel(32'hA5A5_A5A5, 1'b1);
        wait_drained();
        set_formats(FMT_RGBA8, 3'd7);
        queue_pixel(32'h00FF_FFFF, 1'b0);
        queue_pixel(32'hFF01_02FF, 1'b1);
        wait_drained();
        set_formats(3'd7, FMT_RGBA4);
        queue_pixel(32'h1234_56F7, 1'b0);
        queue_pixel(32'hFFFF_FF00, 1'b1);
        wait_drained();

        for (int s = 0; s < 8; s++)
            for (int d = 0; d < 8; d++)
                run_random(FMT_W'(s), FMT_W'(d));
        while (queued_total < ITEM_TARGET)
            run_random(FMT_W'($urandom_range(0, 7)), FMT_W'($urandom_range(0, 7)));

        repeat (LATENCY * 4) @(posedge clk);
        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
